>>> hw/rtl/wnaf_pkg.sv
// ----------------------------------------------------------------------------
// wNAF recoder package
// Shared codes, word unit control and result types for the wNAF scalar
// recoder and its checker.
// ----------------------------------------------------------------------------
package wnaf_pkg;

   localparam int WORD_BITS = 32;
   localparam int MSB_W     = 5;
   localparam int DIGIT_W   = 8;
   localparam int POS_W     = 9;
   localparam int ADDEND_W  = 9;
   localparam int WIN_W     = 3;
   localparam int SWORDS_W  = 4;
   localparam int MAXD_W    = 9;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 9;

   typedef enum logic {
      REQ_LOAD  = 1'b0,
      REQ_DIGIT = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_TOO_LONG = 2'd1,
      STATUS_EMPTY    = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WINDOW_BITS  = 2'd0,
      CSR_SCALAR_WORDS = 2'd1,
      CSR_MAX_DIGITS   = 2'd2
   } csr_index_type;

   typedef enum logic {
      ALU_SCAN = 1'b0,
      ALU_ADD  = 1'b1
   } alu_op_type;

   typedef struct packed {
      alu_op_type          op;
      logic                keep;
      logic [ADDEND_W-1:0] addend;
      logic                carry_in;
      logic [7:0]          clr_mask;
   } alu_ctl_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] sum;
      logic                 carry;
      logic                 nonzero;
      logic [MSB_W-1:0]     msb;
   } alu_res_type;

endpackage

>>> hw/rtl/wnaf_scalar_recoder.sv
// ----------------------------------------------------------------------------
// wNAF scalar recoder
// Recodes a scalar into width-(w+1) non-adjacent form, one digit per request,
// least significant first, using a word-serial value register.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall): a load word writes one 32-bit scalar
//   word and restarts the recoding; a digit request returns one rsp word with
//   the next digit, its position, a last flag and a status code.
//   csr channel (csr_valid / csr_ready): register writes, always ready; write
//   only while the block is idle.
// Sequence, with D = SCALAR_WORDS + 1 words in the value register:
//   a load writes its word and returns nothing;
//   a digit request adds and shifts the D words, one word per cycle
//   through the shared word unit, then runs a flush and the result hand-off;
//   the first request after a load adds a length scan over the D words, and a
//   too-long scalar adds a clear of the value instead of the digit;
//   a request with no digits left goes straight to the hand-off.
// req_stall is high while a request is in progress. The result sits in an
// output register; when rsp_stall holds it, the next result waits in the
// hand-off state. Reset clears the value and restores register defaults.
// ----------------------------------------------------------------------------
module wnaf_scalar_recoder #(
   parameter int SCALAR_WORDS = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_type,
   input  logic [2:0]                            req_word_index,
   input  logic [wnaf_pkg::WORD_BITS-1:0]        req_word_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [wnaf_pkg::DIGIT_W-1:0]   rsp_digit,
   output logic [wnaf_pkg::POS_W-1:0]            rsp_digit_position,
   output logic                                  rsp_digit_last,
   output logic [1:0]                            rsp_status,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [wnaf_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [wnaf_pkg::CSR_DAT_W-1:0]        csr_data
);

   localparam int DEPTH = SCALAR_WORDS + 1;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int BL_W  = $clog2(DEPTH * wnaf_pkg::WORD_BITS + 2);
   localparam int CW    = (BL_W > wnaf_pkg::MAXD_W) ? BL_W : wnaf_pkg::MAXD_W;
   localparam int LW    = (IDX_W > 3) ? IDX_W : 3;
   localparam int NW    = (IDX_W > wnaf_pkg::SWORDS_W) ? IDX_W : wnaf_pkg::SWORDS_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CLEAR,
      ST_DIGIT,
      ST_FLUSH,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic signed [wnaf_pkg::DIGIT_W-1:0] digit;
      logic [wnaf_pkg::POS_W-1:0]          position;
      logic                                last;
      wnaf_pkg::status_type                status;
   } result_type;

   state_type                            state_ff, state_in;
   logic [IDX_W-1:0]                     idx_ff, idx_in;
   logic                                 checked_ff, checked_in;
   logic                                 zero_ff, zero_in;
   logic [wnaf_pkg::POS_W-1:0]           digits_ff, digits_in;
   logic [BL_W-1:0]                      bitlen_ff, bitlen_in;
   logic                                 carry_ff, carry_in;
   logic [wnaf_pkg::WORD_BITS-1:0]       prev_ff, prev_in;
   logic                                 nz_ff, nz_in;
   logic signed [wnaf_pkg::DIGIT_W-1:0]  digit_ff, digit_in;
   result_type                           res_ff, res_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   result_type                           rsp_ff, rsp_in;
   logic [wnaf_pkg::WIN_W-1:0]           window_ff, window_in;
   logic [wnaf_pkg::SWORDS_W-1:0]        swords_ff, swords_in;
   logic [wnaf_pkg::MAXD_W-1:0]          maxd_ff, maxd_in;

   logic                                 mem_we;
   logic [IDX_W-1:0]                     mem_waddr;
   logic [wnaf_pkg::WORD_BITS-1:0]       mem_wdata;
   logic [wnaf_pkg::WORD_BITS-1:0]       mem_rdata;
   wnaf_pkg::alu_ctl_type                alu_ctl;
   wnaf_pkg::alu_res_type                alu_res;

   logic [wnaf_pkg::WIN_W-1:0]           win;
   logic [wnaf_pkg::ADDEND_W-1:0]        win_span;
   logic [7:0]                           win_mask;
   logic [7:0]                           u_raw;
   logic                                 odd;
   logic                                 neg;
   logic [wnaf_pkg::ADDEND_W-1:0]        digit_wide;
   logic signed [wnaf_pkg::DIGIT_W-1:0]  digit_calc;
   logic                                 keep_word;
   logic                                 load_ok;
   logic [BL_W-1:0]                      bitlen_cur;
   logic                                 too_long;
   logic                                 out_free;
   logic                                 idx_last;

   wnaf_value_mem #(
      .DEPTH (DEPTH)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (idx_ff),
      .rd_data (mem_rdata)
   );

   wnaf_word_alu u_alu (
      .operand (mem_rdata),
      .ctl     (alu_ctl),
      .res     (alu_res)
   );

   // Digit arithmetic on the low word.
   always_comb begin
      win        = (window_ff == '0) ? wnaf_pkg::WIN_W'(1) : window_ff;
      win_span   = wnaf_pkg::ADDEND_W'(2) << win;
      win_mask   = 8'(win_span - wnaf_pkg::ADDEND_W'(1));
      u_raw      = mem_rdata[7:0] & win_mask;
      odd        = mem_rdata[0];
      neg        = |(u_raw & 8'(win_span >> 1));
      digit_wide = neg ? ({1'b0, u_raw} - win_span) : {1'b0, u_raw};
      digit_calc = odd ? wnaf_pkg::DIGIT_W'(digit_wide) : '0;
   end

   assign keep_word = (NW'(idx_ff) < NW'(swords_ff))
                      && (idx_ff < IDX_W'(SCALAR_WORDS));
   assign load_ok   = LW'(req_word_index) < LW'(SCALAR_WORDS);
   assign idx_last  = (idx_ff == LAST_IDX);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign bitlen_cur = alu_res.nonzero
                       ? ((BL_W'(idx_ff) << wnaf_pkg::MSB_W) + BL_W'(alu_res.msb)
                          + BL_W'(1))
                       : bitlen_ff;
   assign too_long   = (CW'(bitlen_cur) + CW'(1)) > CW'(maxd_ff);

   // Shared word unit control.
   always_comb begin
      alu_ctl          = '0;
      alu_ctl.op       = wnaf_pkg::ALU_ADD;
      case (state_ff)
         ST_SCAN: begin
            alu_ctl.op   = wnaf_pkg::ALU_SCAN;
            alu_ctl.keep = keep_word;
         end
         ST_DIGIT: begin
            if (idx_ff == '0) begin
               // An odd value loses its low window; a negative digit adds the
               // next window bit, which leaves the same sum as value - digit.
               if (odd) begin
                  alu_ctl.clr_mask = win_mask;
                  alu_ctl.addend   = neg ? win_span : '0;
               end
            end else begin
               alu_ctl.carry_in = carry_ff;
            end
         end
         default: begin
            alu_ctl.keep = 1'b0;
         end
      endcase
   end

   // Value write port.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = idx_ff;
      mem_wdata = '0;
      case (state_ff)
         ST_IDLE: begin
            mem_we    = req_valid && (req_type == wnaf_pkg::REQ_LOAD) && load_ok;
            mem_waddr = IDX_W'(req_word_index);
            mem_wdata = req_word_value;
         end
         ST_SCAN: begin
            mem_we    = 1'b1;
            mem_wdata = alu_res.sum;
         end
         ST_CLEAR: begin
            mem_we = 1'b1;
         end
         ST_DIGIT: begin
            // Shift right by one as the sum ripples up: word i-1 takes bit 0
            // of word i.
            mem_we    = (idx_ff != '0);
            mem_waddr = idx_ff - IDX_W'(1);
            mem_wdata = {alu_res.sum[0], prev_ff[wnaf_pkg::WORD_BITS-1:1]};
         end
         ST_FLUSH: begin
            mem_we    = 1'b1;
            mem_waddr = LAST_IDX;
            mem_wdata = {1'b0, prev_ff[wnaf_pkg::WORD_BITS-1:1]};
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // Sequencer and next values.
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      checked_in   = checked_ff;
      zero_in      = zero_ff;
      digits_in    = digits_ff;
      bitlen_in    = bitlen_ff;
      carry_in     = carry_ff;
      prev_in      = prev_ff;
      nz_in        = nz_ff;
      digit_in     = digit_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      window_in    = window_ff;
      swords_in    = swords_ff;
      maxd_in      = maxd_ff;

      if (csr_valid) begin
         case (csr_index)
            wnaf_pkg::CSR_WINDOW_BITS:  window_in = csr_data[wnaf_pkg::WIN_W-1:0];
            wnaf_pkg::CSR_SCALAR_WORDS: swords_in = csr_data[wnaf_pkg::SWORDS_W-1:0];
            wnaf_pkg::CSR_MAX_DIGITS:   maxd_in   = csr_data[wnaf_pkg::MAXD_W-1:0];
            default: begin
               maxd_in = maxd_ff;
            end
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_type == wnaf_pkg::REQ_LOAD) begin
                  checked_in = 1'b0;
                  digits_in  = '0;
               end else if (!checked_ff) begin
                  state_in  = ST_SCAN;
                  idx_in    = '0;
                  bitlen_in = '0;
               end else if (zero_ff) begin
                  res_in   = '{digit: '0, position: digits_ff, last: 1'b0,
                               status: wnaf_pkg::STATUS_EMPTY};
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_DIGIT;
                  idx_in   = '0;
               end
            end
         end
         ST_SCAN: begin
            bitlen_in = bitlen_cur;
            idx_in    = idx_ff + IDX_W'(1);
            if (idx_last) begin
               checked_in = 1'b1;
               digits_in  = '0;
               idx_in     = '0;
               if (too_long) begin
                  state_in = ST_CLEAR;
               end else if (bitlen_cur == '0) begin
                  zero_in  = 1'b1;
                  res_in   = '{digit: '0, position: '0, last: 1'b0,
                               status: wnaf_pkg::STATUS_EMPTY};
                  state_in = ST_DONE;
               end else begin
                  zero_in  = 1'b0;
                  state_in = ST_DIGIT;
               end
            end
         end
         ST_CLEAR: begin
            idx_in = idx_ff + IDX_W'(1);
            if (idx_last) begin
               idx_in   = '0;
               zero_in  = 1'b1;
               res_in   = '{digit: '0, position: '0, last: 1'b0,
                            status: wnaf_pkg::STATUS_TOO_LONG};
               state_in = ST_DONE;
            end
         end
         ST_DIGIT: begin
            if (idx_ff == '0) begin
               digit_in = digit_calc;
               nz_in    = 1'b0;
            end else begin
               nz_in = nz_ff | (|mem_wdata);
            end
            carry_in = alu_res.carry;
            prev_in  = alu_res.sum;
            idx_in   = idx_ff + IDX_W'(1);
            if (idx_last) begin
               idx_in   = '0;
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            zero_in   = !(nz_ff | (|mem_wdata));
            res_in    = '{digit: digit_ff, position: digits_ff,
                          last: !(nz_ff | (|mem_wdata)),
                          status: wnaf_pkg::STATUS_OK};
            digits_in = digits_ff + wnaf_pkg::POS_W'(1);
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         checked_ff   <= 1'b0;
         zero_ff      <= 1'b1;
         digits_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         window_ff    <= wnaf_pkg::WIN_W'(4);
         swords_ff    <= wnaf_pkg::SWORDS_W'(8);
         maxd_ff      <= wnaf_pkg::MAXD_W'(257);
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         checked_ff   <= checked_in;
         zero_ff      <= zero_in;
         digits_ff    <= digits_in;
         rsp_valid_ff <= rsp_valid_in;
         window_ff    <= window_in;
         swords_ff    <= swords_in;
         maxd_ff      <= maxd_in;
      end
      bitlen_ff <= bitlen_in;
      carry_ff  <= carry_in;
      prev_ff   <= prev_in;
      nz_ff     <= nz_in;
      digit_ff  <= digit_in;
      res_ff    <= res_in;
      rsp_ff    <= rsp_in;
   end

   assign req_stall          = (state_ff != ST_IDLE);
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_digit          = rsp_ff.digit;
   assign rsp_digit_position = rsp_ff.position;
   assign rsp_digit_last     = rsp_ff.last;
   assign rsp_status         = rsp_ff.status;

endmodule

>>> hw/rtl/wnaf_word_alu.sv
// ----------------------------------------------------------------------------
// wNAF word unit
// Shared 32-bit unit: masked add with carry for the digit pass, and
// keep-or-clear with leading-one search for the length scan.
// ----------------------------------------------------------------------------
module wnaf_word_alu (
   input  logic [wnaf_pkg::WORD_BITS-1:0] operand,
   input  wnaf_pkg::alu_ctl_type          ctl,
   output wnaf_pkg::alu_res_type          res
);

   always_comb begin
      logic [wnaf_pkg::WORD_BITS-1:0] masked;
      logic [wnaf_pkg::WORD_BITS:0]   total;
      logic [wnaf_pkg::WORD_BITS-1:0] kept;
      logic [wnaf_pkg::MSB_W-1:0]     msb;

      masked = operand & ~{{(wnaf_pkg::WORD_BITS-8){1'b0}}, ctl.clr_mask};
      total  = {1'b0, masked} + (wnaf_pkg::WORD_BITS+1)'(ctl.addend)
               + (wnaf_pkg::WORD_BITS+1)'(ctl.carry_in);
      kept   = ctl.keep ? operand : '0;

      msb = '0;
      for (int b = 0; b < wnaf_pkg::WORD_BITS; b++) begin
         if (kept[b]) begin
            msb = wnaf_pkg::MSB_W'(b);
         end
      end

      case (ctl.op)
         wnaf_pkg::ALU_ADD: begin
            res.sum   = total[wnaf_pkg::WORD_BITS-1:0];
            res.carry = total[wnaf_pkg::WORD_BITS];
         end
         default: begin
            res.sum   = kept;
            res.carry = 1'b0;
         end
      endcase
      res.nonzero = |res.sum;
      res.msb     = msb;
   end

endmodule

>>> hw/rtl/wnaf_value_mem.sv
// ----------------------------------------------------------------------------
// wNAF value store
// Working value held as a file of 32-bit words, one write and one read
// port. Reset clears the whole value.
// ----------------------------------------------------------------------------
module wnaf_value_mem #(
   parameter int DEPTH = 9
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                wr_en,
   input  logic [$clog2(DEPTH)-1:0]            wr_addr,
   input  logic [wnaf_pkg::WORD_BITS-1:0]      wr_data,
   input  logic [$clog2(DEPTH)-1:0]            rd_addr,
   output logic [wnaf_pkg::WORD_BITS-1:0]      rd_data
);

   logic [wnaf_pkg::WORD_BITS-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            mem_ff[i] <= '0;
         end
      end else if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = mem_ff[rd_addr];

endmodule

>>> hw/rtl/wnaf_checker.sv
// ----------------------------------------------------------------------------
// wNAF recoder checker
// Port-level checks on the recoder's result words and request handshake,
// bound to the top level.
// ----------------------------------------------------------------------------
module wnaf_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic                                 req_type,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic signed [wnaf_pkg::DIGIT_W-1:0]  rsp_digit,
   input logic [wnaf_pkg::POS_W-1:0]           rsp_digit_position,
   input logic                                 rsp_digit_last,
   input logic [1:0]                           rsp_status
);

   // A held result word keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_digit)
         && $stable(rsp_digit_position) && $stable(rsp_digit_last)
         && $stable(rsp_status))
      else $error("stalled result word changed");

   // The block is busy right after it takes a digit request.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_type == wnaf_pkg::REQ_DIGIT) |=> req_stall)
      else $error("digit request did not occupy the block");

   // Error and empty words carry a zero digit and no last flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_status == wnaf_pkg::STATUS_TOO_LONG)
                    || (rsp_status == wnaf_pkg::STATUS_EMPTY))
      |-> (rsp_digit == '0) && !rsp_digit_last)
      else $error("non-digit result carries a digit");

   // A too-long report always sits at position zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == wnaf_pkg::STATUS_TOO_LONG)
      |-> (rsp_digit_position == '0))
      else $error("too-long report at nonzero position");

   // A valid digit is zero or odd, and the last digit is never zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == wnaf_pkg::STATUS_OK)
      |-> (rsp_digit[0] || ((rsp_digit == '0) && !rsp_digit_last)))
      else $error("digit is even and nonzero, or last digit is zero");

endmodule

bind wnaf_scalar_recoder wnaf_checker u_wnaf_checker (.*);

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wNAF scalar recoder testbench
// Loads scalars word by word and pulls digits from the recoder, checking
// every rsp word against a bit-accurate predictor of the recoding. A short
// table of directed rows comes first, then random scalar sequences under
// several register settings and idle patterns on both channels.
// ----------------------------------------------------------------------------
module testbench;

   localparam int VALUE_WORDS = 9;
   localparam int VALUE_BITS  = VALUE_WORDS * wnaf_pkg::WORD_BITS;
   localparam int QUIET_CYCLES = 64;
   localparam int STALL_LIMIT  = 3000;
   localparam int PHASE_ITEMS  = 240;
   localparam int NUM_PHASES   = 6;

   typedef struct packed {
      logic signed [wnaf_pkg::DIGIT_W-1:0] digit;
      logic [wnaf_pkg::POS_W-1:0]          pos;
      logic                                last;
      wnaf_pkg::status_type                status;
   } digit_result_type;

   typedef enum logic [1:0] {
      ROW_LOAD  = 2'd0,
      ROW_DIGIT = 2'd1,
      ROW_CSR   = 2'd2
   } row_kind_type;

   typedef struct packed {
      row_kind_type     kind;
      logic [2:0]       idx;
      logic [31:0]      val;
      logic             typed;
      digit_result_type res;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic                                req_type = wnaf_pkg::REQ_LOAD;
   logic [2:0]                          req_word_index = '0;
   logic [wnaf_pkg::WORD_BITS-1:0]      req_word_value = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic signed [wnaf_pkg::DIGIT_W-1:0] rsp_digit;
   logic [wnaf_pkg::POS_W-1:0]          rsp_digit_position;
   logic                                rsp_digit_last;
   logic [1:0]                          rsp_status;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [wnaf_pkg::CSR_IDX_W-1:0]      csr_index = '0;
   logic [wnaf_pkg::CSR_DAT_W-1:0]      csr_data = '0;

   // Predictor state and register copies.
   logic [VALUE_BITS-1:0]          scal_value = '0;
   logic                           scan_done = 1'b0;
   logic [wnaf_pkg::POS_W-1:0]     emitted_count = '0;
   logic [wnaf_pkg::WIN_W-1:0]     cfg_window = 3'd4;
   logic [wnaf_pkg::SWORDS_W-1:0]  cfg_words = 4'd8;
   logic [wnaf_pkg::MAXD_W-1:0]    cfg_maxd = 9'd257;

   digit_result_type     expected_digits[$];
   directed_row_type     steer_rows[$];
   int                   mismatches = 0;
   int                   snd_idle_pct = 0;
   int                   rcv_idle_pct = 0;
   int                   phase_items = 0;
   wnaf_pkg::status_type last_status = wnaf_pkg::STATUS_OK;
   logic                 last_flag = 1'b0;

   wnaf_scalar_recoder i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_word_index     (req_word_index),
      .req_word_value     (req_word_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_digit          (rsp_digit),
      .rsp_digit_position (rsp_digit_position),
      .rsp_digit_last     (rsp_digit_last),
      .rsp_status         (rsp_status),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // One recoding step: the first request after a load trims the value to the
   // configured word count and runs the length check.
   task automatic recode_digit(output digit_result_type r);
      int               n;
      int               i;
      int               blen;
      int               w;
      int               dval;
      logic [8:0]       full;
      logic [8:0]       u;
      logic             too_long;
      too_long = 1'b0;
      if (!scan_done) begin
         n = (cfg_words > 8) ? 8 : cfg_words;
         for (i = n; i < VALUE_WORDS; i++) begin
            scal_value[i*wnaf_pkg::WORD_BITS +: wnaf_pkg::WORD_BITS] = '0;
         end
         scan_done = 1'b1;
         emitted_count = '0;
         blen = 0;
         for (i = 0; i < VALUE_BITS; i++) begin
            if (scal_value[i]) blen = i + 1;
         end
         if (blen + 1 > cfg_maxd) begin
            scal_value = '0;
            too_long = 1'b1;
         end
      end
      if (too_long) begin
         r = '{8'sd0, 9'd0, 1'b0, wnaf_pkg::STATUS_TOO_LONG};
      end else if (scal_value == '0) begin
         r = '{8'sd0, emitted_count, 1'b0, wnaf_pkg::STATUS_EMPTY};
      end else begin
         w = (cfg_window == 0) ? 1 : cfg_window;
         full = 9'd1 << (w + 1);
         dval = 0;
         if (scal_value[0]) begin
            u = scal_value[8:0] & (full - 9'd1);
            if (u[w]) begin
               dval = int'(u) - int'(full);
               scal_value = scal_value + (full - u);
            end else begin
               dval = int'(u);
               scal_value = scal_value - u;
            end
         end
         scal_value = scal_value >> 1;
         r.digit = dval[7:0];
         r.pos = emitted_count;
         r.last = (scal_value == '0);
         r.status = wnaf_pkg::STATUS_OK;
         emitted_count = emitted_count + 9'd1;
      end
   endtask

   // Drives one request word at the falling edge and waits for it to be taken.
   task automatic send_req(input wnaf_pkg::req_kind_type kind, input logic [2:0] idx,
                           input logic [31:0] val, input logic typed,
                           input digit_result_type typed_res);
      digit_result_type r;
      while ($urandom_range(0, 99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_word_index <= idx;
      req_word_value <= val;
      do @(posedge clock); while (req_stall);
      if (kind == wnaf_pkg::REQ_LOAD) begin
         scal_value[idx*wnaf_pkg::WORD_BITS +: wnaf_pkg::WORD_BITS] = val;
         scan_done = 1'b0;
         emitted_count = '0;
      end else begin
         recode_digit(r);
         last_status = r.status;
         last_flag = r.last;
         expected_digits.push_back(typed ? typed_res : r);
      end
      phase_items++;
      @(negedge clock);
   endtask

   task automatic send_load(input logic [2:0] idx, input logic [31:0] val);
      send_req(wnaf_pkg::REQ_LOAD, idx, val, 1'b0, '0);
   endtask

   task automatic send_digit();
      send_req(wnaf_pkg::REQ_DIGIT, 3'd0, 32'd0, 1'b0, '0);
   endtask

   // Loads leave no result behind, so after the last digit arrives the
   // block is given a latency's worth of cycles before it counts as idle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_digits.size() != 0) @(negedge clock);
      repeat (QUIET_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input wnaf_pkg::csr_index_type idx,
                            input logic [wnaf_pkg::CSR_DAT_W-1:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= d;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         wnaf_pkg::CSR_WINDOW_BITS: begin
            cfg_window = d[wnaf_pkg::WIN_W-1:0];
         end
         wnaf_pkg::CSR_SCALAR_WORDS: begin
            cfg_words = d[wnaf_pkg::SWORDS_W-1:0];
         end
         wnaf_pkg::CSR_MAX_DIGITS: begin
            cfg_maxd = d[wnaf_pkg::MAXD_W-1:0];
         end
         default: begin
         end
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'h0;
         2: return 32'hFFFF_FFFF;
         3: return $urandom() >> $urandom_range(1, 31);
         4: return 32'h1;
         default: return 32'h8000_0000 | $urandom_range(0, 7);
      endcase
   endfunction

   // A full scalar followed by digit requests until the recoding runs out,
   // sometimes cut short, sometimes with a few extra requests past the end.
   task automatic scalar_sequence();
      int k;
      int i;
      int stop_at;
      int cnt;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) k = 1;
      else if (pick < 95) k = $urandom_range(2, 3);
      else k = 8;
      for (i = 0; i < 8; i++) begin
         send_load(i[2:0], (i < k) ? rand_word() : 32'h0);
      end
      stop_at = ($urandom_range(0, 99) < 85) ? 1000 : $urandom_range(1, 20);
      cnt = 0;
      do begin
         send_digit();
         cnt++;
      end while (last_status == wnaf_pkg::STATUS_OK && !last_flag && cnt < stop_at);
      repeat ($urandom_range(0, 2)) send_digit();
   endtask

   task automatic random_burst();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         scalar_sequence();
      end else if (pick < 85) begin
         repeat ($urandom_range(1, 4)) begin
            send_req(wnaf_pkg::req_kind_type'($urandom_range(0, 1)),
                     3'($urandom_range(0, 7)), $urandom(), 1'b0, '0);
         end
      end else begin
         repeat ($urandom_range(1, 3)) send_load(3'($urandom_range(0, 7)), rand_word());
         repeat ($urandom_range(1, 10)) send_digit();
      end
   endtask

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
   end

   always @(posedge clock) begin : rsp_check
      digit_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_digits.size() == 0) begin
            mismatches++;
            $display("%0t: rsp word: expected none, actual digit %0d position %0d",
                     $time, rsp_digit, rsp_digit_position);
         end else begin
            want = expected_digits.pop_front();
            if (rsp_digit !== want.digit) begin
               mismatches++;
               $display("%0t: digit: expected %0d, actual %0d", $time,
                        want.digit, rsp_digit);
            end
            if (rsp_digit_position !== want.pos) begin
               mismatches++;
               $display("%0t: digit_position: expected %0d, actual %0d", $time,
                        want.pos, rsp_digit_position);
            end
            if (rsp_digit_last !== want.last) begin
               mismatches++;
               $display("%0t: digit_last: expected %0b, actual %0b", $time,
                        want.last, rsp_digit_last);
            end
            if (rsp_status !== want.status) begin
               mismatches++;
               $display("%0t: status: expected %0d, actual %0d", $time,
                        want.status, rsp_status);
            end
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("testbench: errors");
      $finish;
   end

   initial begin : stimulus
      int ph;
      int ph_window[NUM_PHASES];
      int ph_words[NUM_PHASES];
      int ph_maxd[NUM_PHASES];
      int ph_snd[NUM_PHASES];
      int ph_rcv[NUM_PHASES];

      ph_window = '{4, 1, 7, 0, 5, 7};
      ph_words  = '{8, 1, 15, 2, 0, 8};
      ph_maxd   = '{257, 40, 511, 66, 0, 200};
      ph_snd    = '{31, 31, 76, 76, 0, 0};
      ph_rcv    = '{76, 76, 31, 31, 0, 0};

      // After reset the value is zero, so the first requests find nothing.
      steer_rows.push_back('{ROW_DIGIT, 3'd0, 32'd0, 1'b1,
                             '{8'sd0, 9'd0, 1'b0, wnaf_pkg::STATUS_EMPTY}});
      steer_rows.push_back('{ROW_DIGIT, 3'd0, 32'd0, 1'b1,
                             '{8'sd0, 9'd0, 1'b0, wnaf_pkg::STATUS_EMPTY}});
      steer_rows.push_back('{ROW_LOAD, 3'd0, 32'd1, 1'b0, '0});
      steer_rows.push_back('{ROW_DIGIT, 3'd0, 32'd0, 1'b1,
                             '{8'sd1, 9'd0, 1'b1, wnaf_pkg::STATUS_OK}});
      steer_rows.push_back('{ROW_DIGIT, 3'd0, 32'd0, 1'b1,
                             '{8'sd0, 9'd1, 1'b0, wnaf_pkg::STATUS_EMPTY}});
      steer_rows.push_back('{ROW_LOAD, 3'd0, 32'h1F, 1'b0, '0});
      steer_rows.push_back('{ROW_DIGIT, 3'd0, 32'd0, 1'b1,
                             '{-8'sd1, 9'd0, 1'b0, wnaf_pkg::STATUS_OK}});
      steer_rows.push_back('{ROW_DIGIT, 3'd0, 32'd0, 1'b0, '0});
      // Top word set: 257 digits exactly fits the default capacity.
      steer_rows.push_back('{ROW_LOAD, 3'd7, 32'hFFFF_FFFF, 1'b0, '0});
      steer_rows.push_back('{ROW_DIGIT, 3'd0, 32'd0, 1'b0, '0});
      steer_rows.push_back('{ROW_CSR, 3'(wnaf_pkg::CSR_MAX_DIGITS), 32'd256, 1'b0, '0});
      steer_rows.push_back('{ROW_LOAD, 3'd7, 32'hFFFF_FFFF, 1'b0, '0});
      steer_rows.push_back('{ROW_DIGIT, 3'd0, 32'd0, 1'b1,
                             '{8'sd0, 9'd0, 1'b0, wnaf_pkg::STATUS_TOO_LONG}});
      steer_rows.push_back('{ROW_DIGIT, 3'd0, 32'd0, 1'b1,
                             '{8'sd0, 9'd0, 1'b0, wnaf_pkg::STATUS_EMPTY}});
      // Widest window gives the digit extremes.
      steer_rows.push_back('{ROW_CSR, 3'(wnaf_pkg::CSR_WINDOW_BITS), 32'd7, 1'b0, '0});
      steer_rows.push_back('{ROW_LOAD, 3'd7, 32'd0, 1'b0, '0});
      steer_rows.push_back('{ROW_LOAD, 3'd0, 32'h81, 1'b0, '0});
      steer_rows.push_back('{ROW_DIGIT, 3'd0, 32'd0, 1'b1,
                             '{-8'sd127, 9'd0, 1'b0, wnaf_pkg::STATUS_OK}});
      steer_rows.push_back('{ROW_LOAD, 3'd0, 32'h7F, 1'b0, '0});
      steer_rows.push_back('{ROW_DIGIT, 3'd0, 32'd0, 1'b1,
                             '{8'sd127, 9'd0, 1'b1, wnaf_pkg::STATUS_OK}});
      // A zero window behaves as a window of one.
      steer_rows.push_back('{ROW_CSR, 3'(wnaf_pkg::CSR_WINDOW_BITS), 32'd0, 1'b0, '0});
      steer_rows.push_back('{ROW_LOAD, 3'd0, 32'd3, 1'b0, '0});
      steer_rows.push_back('{ROW_DIGIT, 3'd0, 32'd0, 1'b1,
                             '{-8'sd1, 9'd0, 1'b0, wnaf_pkg::STATUS_OK}});
      steer_rows.push_back('{ROW_DIGIT, 3'd0, 32'd0, 1'b0, '0});
      // With no words in use the scalar reads as zero.
      steer_rows.push_back('{ROW_CSR, 3'(wnaf_pkg::CSR_SCALAR_WORDS), 32'd0, 1'b0, '0});
      steer_rows.push_back('{ROW_LOAD, 3'd0, 32'd5, 1'b0, '0});
      steer_rows.push_back('{ROW_DIGIT, 3'd0, 32'd0, 1'b1,
                             '{8'sd0, 9'd0, 1'b0, wnaf_pkg::STATUS_EMPTY}});

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (steer_rows[i]) begin
         case (steer_rows[i].kind)
            ROW_CSR: begin
               wait_idle();
               write_csr(wnaf_pkg::csr_index_type'(steer_rows[i].idx[1:0]),
                         steer_rows[i].val[8:0]);
            end
            ROW_LOAD: begin
               send_load(steer_rows[i].idx, steer_rows[i].val);
            end
            default: begin
               send_req(wnaf_pkg::REQ_DIGIT, 3'd0, 32'd0, steer_rows[i].typed,
                        steer_rows[i].res);
            end
         endcase
      end

      for (ph = 0; ph < NUM_PHASES; ph++) begin
         wait_idle();
         snd_idle_pct = ph_snd[ph];
         rcv_idle_pct = ph_rcv[ph];
         write_csr(wnaf_pkg::CSR_WINDOW_BITS, wnaf_pkg::CSR_DAT_W'(ph_window[ph]));
         write_csr(wnaf_pkg::CSR_SCALAR_WORDS, wnaf_pkg::CSR_DAT_W'(ph_words[ph]));
         write_csr(wnaf_pkg::CSR_MAX_DIGITS, wnaf_pkg::CSR_DAT_W'(ph_maxd[ph]));
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) random_burst();
      end

      wait_idle();
      if (mismatches == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule
